/* sv/in_place_bucket_sort_assert.svh */
// ----------------------------------------------------------------------------
// in_place_bucket_sort_assert.svh
// assertion macros for the in-place bucket sorter
// ----------------------------------------------------------------------------
`ifndef IN_PLACE_BUCKET_SORT_ASSERT_SVH
`define IN_PLACE_BUCKET_SORT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define IPBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define IPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ipbs_pkg.sv */
// ----------------------------------------------------------------------------
// ipbs_pkg
// types and fixed widths of the in-place bucket sorter
// ----------------------------------------------------------------------------
package ipbs_pkg;

	// fixed field widths
	localparam int OUT_W = 32;
	localparam int LBL_W = 4;
	localparam int CFG_W = 5;

	// bucket total after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFFS,
		ST_TOP,
		ST_SKIP,
		ST_LAB,
		ST_SCAN,
		ST_SCANCHK,
		ST_SWAP,
		ST_EMIT
	} state_t;

endpackage

/* sv/in_place_bucket_sort.sv */
// ----------------------------------------------------------------------------
// in_place_bucket_sort
// batch loader, in-place counting permutation and sequential emitter
// ----------------------------------------------------------------------------
// Usage
//   Items come in on payload / bucket_label / batch_end; a transfer happens at
//   a clock edge with start high and busy low. Busy stays low after each load,
//   so loads can follow back to back. Items with a label not
//   below bucket_total (capped at MAX_BUCKETS) or beyond MAX_ITEMS are dropped
//   and flag batch_error for the batch.
//   The item with batch_end set raises busy: the bucket offsets are built
//   bucket by bucket with one shared adder, then the permutation walks the
//   store through the item memory, one read a cycle: examining a position
//   passes states TOP, SKIP and LAB, each slot checked in a bucket scan
//   SCAN and SCANCHK, the swap write SWAP, and each finished bucket SKIP.
//   Emission then reads one item a cycle; each result is shown for one cycle
//   with result_strobe, the first one in the cycle after emission starts, the
//   last one with final_item set. An empty batch yields a single zero result.
//   busy drops in the cycle of the last result; the receiver cannot stall.
//   bucket_total is written by cfg_we / cfg_wdata; the user must write it
//   only while busy is low, the block itself does not enforce it.
//   Reset clears counters, flags and the sequencer; the item memory holds
//   nothing meaningful until loaded and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "in_place_bucket_sort_assert.svh"

module in_place_bucket_sort #(
	parameter int MAX_ITEMS    = 64,
	parameter int MAX_BUCKETS  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ipbs_pkg::OUT_W-1:0]  payload,
	input  logic [ipbs_pkg::LBL_W-1:0]  bucket_label,
	input  logic                        batch_end,
	input  logic                        cfg_we,
	input  logic [ipbs_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                        result_strobe,
	output logic [ipbs_pkg::OUT_W-1:0]  sorted_payload,
	output logic [ipbs_pkg::LBL_W-1:0]  sorted_label,
	output logic                        final_item,
	output logic                        batch_error
);
	import ipbs_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int BKT_W = $clog2(MAX_BUCKETS);

	// control and batch state
	state_t                state_q, state_d;
	logic [CFG_W-1:0]      bucket_total_q;
	logic [CNT_W-1:0]      item_count_q;
	logic                  error_q;
	logic [CNT_W-1:0]      count_q [MAX_BUCKETS];
	logic [CNT_W-1:0]      end_q   [MAX_BUCKETS];
	logic [CNT_W-1:0]      next_q  [MAX_BUCKETS];

	// sequencer working registers
	logic [BKT_W-1:0]      b_q;
	logic [CNT_W-1:0]      run_q;
	logic [CNT_W-1:0]      pos_q;
	logic [BKT_W-1:0]      cur_q;
	logic [LBL_W-1:0]      lab_q;
	logic [PAYLOAD_BITS-1:0] held_q;
	logic [CNT_W-1:0]      slot_q;
	logic [CNT_W-1:0]      emit_q;

	// item memory
	logic [PAYLOAD_BITS-1:0] pay_mem [MAX_ITEMS];
	logic [LBL_W-1:0]      lbl_mem [MAX_ITEMS];
	logic [PAYLOAD_BITS-1:0] rd_pay_q;
	logic [LBL_W-1:0]      rd_lbl_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [IDX_W-1:0]      mem_raddr;
	logic [PAYLOAD_BITS-1:0] mem_wpay;
	logic [LBL_W-1:0]      mem_wlbl;

	// emission pipeline
	logic                  valid_s1;
	logic                  last_s1;
	logic                  zero_s1;
	logic                  err_s1;

	// shared compare terms
	logic                  load;
	logic                  lab_ok;
	logic [BKT_W-1:0]      lab_idx;
	logic [BKT_W-1:0]      bkt_idx;
	logic [BKT_W-1:0]      nxt_idx;
	logic [CNT_W-1:0]      cnt_rd;
	logic [CNT_W-1:0]      nxt_rd;
	logic [CNT_W-1:0]      end_rd;
	logic [CNT_W-1:0]      run_sum;
	logic [PAYLOAD_BITS-1:0] pay_in;
	logic                  few_items;
	logic                  pos_done;
	logic                  past_end;
	logic                  last_bkt;
	logic                  lab_here;
	logic                  slot_out;
	logic                  slot_placed;
	logic                  emit_last;

	assign busy    = (state_q != ST_IDLE);
	assign load    = start && !busy;
	assign pay_in  = PAYLOAD_BITS'(payload);
	assign lab_ok  = ({1'b0, bucket_label} < bucket_total_q)
		&& (int'(bucket_label) < MAX_BUCKETS)
		&& (item_count_q < CNT_W'(MAX_ITEMS));
	assign lab_idx = BKT_W'(bucket_label);

	// one read index per bucket array
	assign bkt_idx = (state_q == ST_IDLE) ? lab_idx : b_q;
	assign nxt_idx = (state_q == ST_SKIP) ? cur_q + BKT_W'(1) : BKT_W'(lab_q);
	assign cnt_rd  = count_q[bkt_idx];
	assign nxt_rd  = next_q[nxt_idx];
	assign end_rd  = end_q[cur_q];
	assign run_sum = run_q + cnt_rd;

	// sequencer decisions
	assign few_items   = (item_count_q < CNT_W'(2));
	assign pos_done    = !(pos_q < item_count_q - CNT_W'(1));
	assign past_end    = (pos_q >= end_rd);
	assign last_bkt    = (cur_q == BKT_W'(MAX_BUCKETS - 1));
	assign lab_here    = (rd_lbl_q == LBL_W'(cur_q));
	assign slot_out    = (nxt_rd >= item_count_q);
	assign slot_placed = (rd_lbl_q == lab_q);
	assign emit_last   = (item_count_q == '0) || (emit_q == item_count_q - CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load && batch_end) state_d = ST_OFFS;
			end
			ST_OFFS: begin
				if (b_q == BKT_W'(MAX_BUCKETS - 1)) state_d = few_items ? ST_EMIT : ST_TOP;
			end
			ST_TOP: begin
				state_d = pos_done ? ST_EMIT : ST_SKIP;
			end
			ST_SKIP: begin
				if (past_end) begin
					if (last_bkt) state_d = ST_EMIT;
				end else if (pos_q >= item_count_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_LAB;
				end
			end
			ST_LAB: begin
				state_d = lab_here ? ST_TOP : ST_SCAN;
			end
			ST_SCAN: begin
				state_d = slot_out ? ST_EMIT : ST_SCANCHK;
			end
			ST_SCANCHK: begin
				state_d = slot_placed ? ST_SCAN : ST_SWAP;
			end
			ST_SWAP: begin
				state_d = ST_TOP;
			end
			ST_EMIT: begin
				if (emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = item_count_q[IDX_W-1:0];
		mem_wpay  = pay_in;
		mem_wlbl  = bucket_label;
		mem_raddr = pos_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				mem_we = load && lab_ok;
			end
			ST_SCAN: begin
				mem_raddr = nxt_rd[IDX_W-1:0];
			end
			ST_SCANCHK: begin
				mem_we    = !slot_placed;
				mem_waddr = pos_q[IDX_W-1:0];
				mem_wpay  = rd_pay_q;
				mem_wlbl  = rd_lbl_q;
			end
			ST_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q[IDX_W-1:0];
				mem_wpay  = held_q;
				mem_wlbl  = lab_q;
			end
			ST_EMIT: begin
				mem_raddr = emit_q[IDX_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// item memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pay_mem[mem_waddr] <= mem_wpay;
			lbl_mem[mem_waddr] <= mem_wlbl;
		end
		rd_pay_q <= pay_mem[mem_raddr];
		rd_lbl_q <= lbl_mem[mem_raddr];
	end

	// state, config and bucket tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bucket_total_q <= CFG_RESET;
			item_count_q   <= '0;
			error_q        <= 1'b0;
			b_q            <= '0;
			run_q          <= '0;
			pos_q          <= '0;
			cur_q          <= '0;
			emit_q         <= '0;
			valid_s1       <= 1'b0;
			for (int i = 0; i < MAX_BUCKETS; i++) begin
				count_q[i] <= '0;
				end_q[i]   <= '0;
				next_q[i]  <= '0;
			end
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_EMIT);
			if (cfg_we) bucket_total_q <= cfg_wdata;
			emit_q <= (state_q == ST_EMIT) ? emit_q + CNT_W'(1) : '0;
			case (state_q)
				// load one item
				ST_IDLE: begin
					b_q   <= '0;
					run_q <= '0;
					if (load) begin
						if (lab_ok) begin
							count_q[lab_idx] <= cnt_rd + CNT_W'(1);
							item_count_q     <= item_count_q + CNT_W'(1);
						end else begin
							error_q <= 1'b1;
						end
					end
				end
				// prefix sums, one bucket a cycle
				ST_OFFS: begin
					end_q[b_q]  <= run_sum;
					next_q[b_q] <= run_q;
					run_q       <= run_sum;
					b_q         <= b_q + BKT_W'(1);
					pos_q       <= '0;
					cur_q       <= '0;
				end
				// step over finished bucket regions
				ST_SKIP: begin
					if (past_end && !last_bkt) begin
						cur_q <= cur_q + BKT_W'(1);
						pos_q <= nxt_rd;
					end
				end
				// entry already in its own bucket
				ST_LAB: begin
					if (lab_here) pos_q <= pos_q + CNT_W'(1);
				end
				// advance past placed entries of the target bucket
				ST_SCANCHK: begin
					if (slot_placed) next_q[nxt_idx] <= nxt_rd + CNT_W'(1);
				end
				// second half of the swap
				ST_SWAP: begin
					next_q[nxt_idx] <= nxt_rd + CNT_W'(1);
				end
				// batch state clears with the last read
				ST_EMIT: begin
					if (emit_last) begin
						item_count_q <= '0;
						error_q      <= 1'b0;
						for (int i = 0; i < MAX_BUCKETS; i++) count_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// swap operands and emission flags, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_LAB) begin
			lab_q  <= rd_lbl_q;
			held_q <= rd_pay_q;
		end
		if (state_q == ST_SCAN) slot_q <= nxt_rd;
		last_s1 <= emit_last;
		zero_s1 <= (item_count_q == '0);
		err_s1  <= error_q;
	end

	// result ports
	assign result_strobe  = valid_s1;
	assign sorted_payload = zero_s1 ? '0 : OUT_W'(rd_pay_q);
	assign sorted_label   = zero_s1 ? '0 : rd_lbl_q;
	assign final_item     = last_s1;
	assign batch_error    = err_s1;

	`IPBS_ASSERT_NOW(a_strobe_from_emit, result_strobe, $past(state_q) == ST_EMIT, "result transfer without emission read")
	`IPBS_ASSERT_NEXT(a_final_ends_batch, result_strobe && final_item, !result_strobe, "result transfer after final item")
	`IPBS_ASSERT_NOW(a_permute_needs_two, state_q == ST_TOP || state_q == ST_SKIP || state_q == ST_LAB || state_q == ST_SWAP, item_count_q >= CNT_W'(2), "permutation with fewer than two items")
	`IPBS_ASSERT_NOW(a_swap_in_range, state_q == ST_SWAP, slot_q < item_count_q && pos_q < item_count_q, "swap outside loaded items")

endmodule

/* tb/in_place_bucket_sort_tb.sv */
// ----------------------------------------------------------------------------
// in_place_bucket_sort_tb
// self-checking bench for the in-place bucket sorter
// ----------------------------------------------------------------------------
// A queue of planned loads and bucket_total writes is filled up front. A
// clocked driver walks it with random hold-offs. Each accepted load goes
// through a software copy of the counting sort, which queues the words the
// block must emit. A clocked monitor compares every strobed result against
// the oldest queued word. Directed batches cover the field extremes, dropped
// labels, an empty batch, a total of zero, the capped total and a total
// change in the middle of a batch. Random batches follow, one of them larger
// than the store.
// ----------------------------------------------------------------------------
module in_place_bucket_sort_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipbs_pkg::*;

	localparam int N_ITEMS     = 64;
	localparam int N_BUCKETS   = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 3;
	localparam int RAND_ITEMS  = 200;

	// one planned transfer: a load or a register write
	typedef struct {
		bit               is_cfg;
		logic [CFG_W-1:0] cfg_val;
		logic [OUT_W-1:0] pay;
		logic [LBL_W-1:0] lab;
		logic             last;
		int               gap;
	} plan_t;

	// one emitted word
	typedef struct {
		logic [OUT_W-1:0] pay;
		logic [LBL_W-1:0] lab;
		logic             fin;
		logic             err;
	} sorted_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [OUT_W-1:0] payload = '0;
	logic [LBL_W-1:0] bucket_label = '0;
	logic             batch_end = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             result_strobe;
	logic [OUT_W-1:0] sorted_payload;
	logic [LBL_W-1:0] sorted_label;
	logic             final_item;
	logic             batch_error;

	plan_t   item_plan[$];
	sorted_t sorted_expect[$];

	// software copy of the sorter state
	logic [OUT_W-1:0] pay_mem [N_ITEMS];
	logic [LBL_W-1:0] lbl_mem [N_ITEMS];
	logic [6:0]       bkt_cnt [N_BUCKETS];
	logic [6:0]       bkt_end [N_BUCKETS];
	logic [6:0]       bkt_next[N_BUCKETS];
	logic [6:0]       fill;
	logic             drop_seen;
	logic [CFG_W-1:0] total_now;

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  cfg_writes;
	int  batches;
	int  err_batches;
	int  empty_batches;
	int  idle_cnt;
	int  quiet;
	bit  calm;
	logic [CFG_W-1:0] plan_total;

	in_place_bucket_sort u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.payload       (payload),
		.bucket_label  (bucket_label),
		.batch_end     (batch_end),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result_strobe (result_strobe),
		.sorted_payload(sorted_payload),
		.sorted_label  (sorted_label),
		.final_item    (final_item),
		.batch_error   (batch_error)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// load one item and, on the batch end, sort the store and queue the output
	task automatic load_and_sort(input logic [OUT_W-1:0] pay, input logic [LBL_W-1:0] lab,
			input logic last);
		int      cap, n, pos, cur, lb, slot, p;
		bit      stop;
		logic [OUT_W-1:0] held;
		sorted_t w;
		cap = (total_now < N_BUCKETS) ? int'(total_now) : N_BUCKETS;
		if (int'(lab) >= cap || fill >= N_ITEMS) begin
			drop_seen = 1'b1;
		end else begin
			pay_mem[fill] = pay;
			lbl_mem[fill] = lab;
			bkt_cnt[lab]  = bkt_cnt[lab] + 7'd1;
			fill          = fill + 7'd1;
		end
		if (!last)
			return;

		// bucket end offsets and first free slots
		bkt_end[0]  = bkt_cnt[0];
		bkt_next[0] = '0;
		for (int b = 1; b < N_BUCKETS; b++) begin
			bkt_end[b]  = bkt_end[b-1] + bkt_cnt[b];
			bkt_next[b] = bkt_next[b-1] + bkt_cnt[b-1];
		end

		// in-place permutation, same swap order as the block
		n = int'(fill);
		if (n >= 2) begin
			pos  = 0;
			cur  = 0;
			stop = 0;
			while (!stop && pos < n - 1) begin
				// step past buckets whose region is done
				while (pos >= int'(bkt_end[cur])) begin
					cur++;
					if (cur == N_BUCKETS)
						break;
					pos = int'(bkt_next[cur]);
				end
				if (cur == N_BUCKETS || pos >= n) begin
					stop = 1;
				end else begin
					lb = int'(lbl_mem[pos]);
					if (lb != cur) begin
						while (int'(bkt_next[lb]) < n && int'(lbl_mem[bkt_next[lb]]) == lb)
							bkt_next[lb] = bkt_next[lb] + 7'd1;
						if (int'(bkt_next[lb]) >= n) begin
							stop = 1;
						end else begin
							slot          = int'(bkt_next[lb]);
							held          = pay_mem[pos];
							lbl_mem[pos]  = lbl_mem[slot];
							lbl_mem[slot] = lb[LBL_W-1:0];
							pay_mem[pos]  = pay_mem[slot];
							pay_mem[slot] = held;
							bkt_next[lb]  = bkt_next[lb] + 7'd1;
							pos--;
						end
					end
					if (!stop)
						pos++;
				end
			end
		end

		// emission order
		if (n == 0) begin
			w = '{pay: '0, lab: '0, fin: 1'b1, err: drop_seen};
			sorted_expect.push_back(w);
			empty_batches++;
		end else begin
			for (p = 0; p < n; p++) begin
				w = '{pay: pay_mem[p], lab: lbl_mem[p], fin: (p == n - 1), err: drop_seen};
				sorted_expect.push_back(w);
			end
		end
		if (drop_seen)
			err_batches++;
		batches++;
		fill      = '0;
		drop_seen = 1'b0;
		for (int b = 0; b < N_BUCKETS; b++)
			bkt_cnt[b] = '0;
	endtask

	// driver: loads with hold-offs, register writes only once the block is quiet
	always @(posedge clk) begin
		plan_t head;
		logic  n_start;
		logic  n_we;
		if (!arst_n) begin
			start    <= 1'b0;
			cfg_we   <= 1'b0;
			idle_cnt = 0;
		end else begin
			n_start = start;
			n_we    = 1'b0;
			if (cfg_we) begin
				total_now = cfg_wdata;
				cfg_writes++;
			end
			if (start && !busy) begin
				load_and_sort(payload, bucket_label, batch_end);
				items_sent++;
				n_start  = 1'b0;
				idle_cnt = 0;
			end
			if (!n_start && item_plan.size() > 0) begin
				head = item_plan[0];
				if (head.is_cfg) begin
					if (!busy && !start && sorted_expect.size() == 0)
						idle_cnt++;
					else
						idle_cnt = 0;
					if (idle_cnt >= SETTLE) begin
						n_we = 1'b1;
						cfg_wdata <= head.cfg_val;
						void'(item_plan.pop_front());
						idle_cnt = 0;
					end
				end else if (idle_cnt >= head.gap) begin
					n_start = 1'b1;
					payload      <= head.pay;
					bucket_label <= head.lab;
					batch_end    <= head.last;
					void'(item_plan.pop_front());
					idle_cnt = 0;
				end else begin
					idle_cnt++;
				end
			end
			start  <= n_start;
			cfg_we <= n_we;
		end
	end

	task automatic check_field(input string what, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// monitor: every strobed result against the oldest queued word
	always @(posedge clk) begin
		sorted_t w;
		if (arst_n && result_strobe) begin
			results_seen++;
			if (sorted_expect.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h/%h/%b/%b",
					$time, sorted_payload, sorted_label, final_item, batch_error);
				mismatches++;
			end else begin
				w = sorted_expect.pop_front();
				check_field("sorted_payload", w.pay, sorted_payload);
				check_field("sorted_label", OUT_W'(w.lab), OUT_W'(sorted_label));
				check_field("final_item", OUT_W'(w.fin), OUT_W'(final_item));
				check_field("batch_error", OUT_W'(w.err), OUT_W'(batch_error));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_strobe || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 13));
	endfunction

	task automatic plan_item(input logic [OUT_W-1:0] pay, input logic [LBL_W-1:0] lab,
			input logic last);
		plan_t e;
		e = '{is_cfg: 1'b0, cfg_val: '0, pay: pay, lab: lab, last: last, gap: draw_gap()};
		item_plan.push_back(e);
	endtask

	task automatic plan_cfg(input logic [CFG_W-1:0] val);
		plan_t e;
		e = '{is_cfg: 1'b1, cfg_val: val, pay: '0, lab: '0, last: 1'b0, gap: 0};
		item_plan.push_back(e);
		plan_total = val;
	endtask

	function automatic logic [OUT_W-1:0] draw_payload();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return OUT_W'($urandom);
	endfunction

	initial begin
		int rand_items, batch_no, len, eff;
		logic [LBL_W-1:0] lab;
		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		cfg_writes    = 0;
		batches       = 0;
		err_batches   = 0;
		empty_batches = 0;
		quiet         = 0;
		fill          = '0;
		drop_seen     = 1'b0;
		total_now     = CFG_RESET;
		plan_total    = CFG_RESET;
		calm          = 0;
		for (int b = 0; b < N_BUCKETS; b++) begin
			bkt_cnt[b]  = '0;
			bkt_end[b]  = '0;
			bkt_next[b] = '0;
		end

		// directed: reset total, field extremes, mixed buckets
		plan_item('0, 4'd7, 1'b0);
		plan_item('1, 4'd0, 1'b0);
		plan_item(draw_payload(), 4'd3, 1'b0);
		plan_item(draw_payload(), 4'd7, 1'b0);
		plan_item(draw_payload(), 4'd0, 1'b0);
		plan_item(draw_payload(), 4'd5, 1'b1);
		// bad label alone gives an empty batch with the error flag
		plan_item(draw_payload(), 4'd15, 1'b1);
		// single kept item
		plan_item(draw_payload(), 4'd2, 1'b1);
		// full bucket range
		plan_cfg(5'd16);
		plan_item(draw_payload(), 4'd15, 1'b0);
		plan_item(draw_payload(), 4'd0, 1'b0);
		plan_item(draw_payload(), 4'd15, 1'b0);
		plan_item(draw_payload(), 4'd8, 1'b0);
		plan_item(draw_payload(), 4'd9, 1'b1);
		// one bucket, one item dropped
		plan_cfg(5'd1);
		plan_item(draw_payload(), 4'd0, 1'b0);
		plan_item(draw_payload(), 4'd1, 1'b0);
		plan_item(draw_payload(), 4'd0, 1'b1);
		// zero total drops everything
		plan_cfg(5'd0);
		plan_item(draw_payload(), 4'd0, 1'b1);
		// total above the cap, then lowered in the middle of a batch
		plan_cfg(5'd31);
		plan_item(draw_payload(), 4'd12, 1'b0);
		plan_cfg(5'd4);
		plan_item(draw_payload(), 4'd12, 1'b0);
		plan_item(draw_payload(), 4'd3, 1'b1);

		// random batches, one of them past the store size
		rand_items = 0;
		batch_no   = 0;
		while (rand_items < RAND_ITEMS) begin
			if (batch_no % 3 == 0)
				plan_cfg(($urandom_range(0, 2) == 0) ? CFG_W'($urandom_range(0, 31))
					: CFG_W'($urandom_range(1, 16)));
			if (batch_no == 4)
				plan_cfg(5'd16);
			calm = ($urandom_range(0, 3) == 0);
			len  = (batch_no == 4) ? N_ITEMS + 2 : int'($urandom_range(1, 12));
			eff  = (plan_total < N_BUCKETS) ? int'(plan_total) : N_BUCKETS;
			for (int k = 0; k < len; k++) begin
				if (eff == 0 || $urandom_range(0, 9) == 0)
					lab = LBL_W'($urandom_range(0, 15));
				else
					lab = LBL_W'($urandom_range(0, eff - 1));
				plan_item(draw_payload(), lab, k == len - 1);
			end
			rand_items += len;
			batch_no++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// drain the plan, then the expected words, then a short tail
		while (item_plan.size() > 0 || start)
			@(posedge clk);
		while (sorted_expect.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sorted_expect.size() > 0) begin
			$display("%0t: %0d results never came", $time, sorted_expect.size());
			mismatches++;
		end
		$display("covered %0d loads in %0d batches, %0d results, %0d register writes",
			items_sent, batches, results_seen, cfg_writes);
		$display("batches with drops: %0d, empty batches: %0d, mismatches: %0d",
			err_batches, empty_batches, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
